### rtl/core/skvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants of the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned ValW        = 32;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_SET     = 2'd1,
    CMD_GET_INS = 2'd2,
    CMD_SET_ALL = 2'd3
  } cmd_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                   cmp;
    logic                   ins;
    logic                   upd;
    logic                   all;
    logic signed [KeyW-1:0] key;
    logic [ValW-1:0]        value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/skvt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skvt_cell
// One table entry: compares its key against the request and shifts right
// from its left neighbor on a sorted insert.
// ----------------------------------------------------------------------------
module skvt_cell (
  input  logic                                  clk_i,
  input  skvt_pkg::cell_ctrl_t                  ctrl_i,
  input  logic                                  occ_i,
  input  logic                                  left_lt_i,
  input  logic signed [skvt_pkg::KeyW-1:0]      left_key_i,
  input  logic [skvt_pkg::ValW-1:0]             left_value_i,
  output logic                                  lt_o,
  output logic                                  eq_o,
  output logic signed [skvt_pkg::KeyW-1:0]      key_o,
  output logic [skvt_pkg::ValW-1:0]             value_o,
  output logic [skvt_pkg::ValW-1:0]             hit_value_o
);
  import skvt_pkg::*;

  logic signed [KeyW-1:0] key_q;
  logic [ValW-1:0]        value_q;
  logic                   lt_q;
  logic                   eq_q;

  // compare phase
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      lt_q <= occ_i && (key_q < ctrl_i.key);
      eq_q <= occ_i && (key_q == ctrl_i.key);
    end
  end

  // update phase
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      if (!lt_q) begin
        if (left_lt_i) begin
          key_q   <= ctrl_i.key;
          value_q <= ctrl_i.value;
        end else begin
          key_q   <= left_key_i;
          value_q <= left_value_i;
        end
      end
    end else if (ctrl_i.all || (ctrl_i.upd && eq_q)) begin
      value_q <= ctrl_i.value;
    end
  end

  assign lt_o        = lt_q;
  assign eq_o        = eq_q;
  assign key_o       = key_q;
  assign value_o     = value_q;
  assign hit_value_o = eq_q ? value_q : '0;

endmodule
`default_nettype wire

### rtl/core/sorted_key_value_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Sorted key/value table built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each request passes through the compare state ST_CMP, in which every cell
// compares its signed key with the request key, and then ST_APPLY, in which
// the cells update, shift right by one place on an insert, and the result
// register loads. The next request is taken in ST_APPLY, so a new request is
// accepted while the last one completes as long as the result side keeps up;
// a held result stalls ST_APPLY. There is no clearing pass after reset. The
// cmd field travels on s_axis_tuser; found and status travel on m_axis_tuser.
module sorted_key_value_table #(
  parameter int unsigned CAPACITY = skvt_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
  input  logic [1:0]  s_axis_tuser,   // cmd [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_value [31:0]
  output logic [1:0]  m_axis_tuser    // found [0], status [1]
);
  import skvt_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CMP   = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  cmd_e                   cmd_q;
  logic signed [KeyW-1:0] key_q;
  logic [ValW-1:0]        value_q;
  logic                   m_valid_q, m_valid_d;
  logic [31:0]            m_data_q;
  logic [1:0]             m_user_q;

  cell_ctrl_t             ctrl;
  logic                   accept;
  logic                   apply_go;
  logic                   hit;
  logic                   full;
  logic                   need_ins;
  logic [ValW-1:0]        hit_value;
  logic [31:0]            res_value;

  logic                   lt   [CAPACITY];
  logic                   eq   [CAPACITY];
  logic signed [KeyW-1:0] keys [CAPACITY];
  logic [ValW-1:0]        vals [CAPACITY];
  logic [ValW-1:0]        hvals[CAPACITY];

  assign apply_go      = (state_q == ST_APPLY) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) || apply_go;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(CAPACITY));

  always_comb begin
    hit       = 1'b0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit       = hit | eq[i];
      hit_value = hit_value | hvals[i];
    end
  end

  assign need_ins = ((cmd_q == CMD_SET) || (cmd_q == CMD_GET_INS)) && !hit;

  always_comb begin
    ctrl.cmp   = (state_q == ST_CMP);
    ctrl.ins   = apply_go && need_ins && !full;
    ctrl.upd   = apply_go && (cmd_q == CMD_SET) && hit;
    ctrl.all   = apply_go && (cmd_q == CMD_SET_ALL);
    ctrl.key   = key_q;
    ctrl.value = value_q;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                   left_lt;
    logic signed [KeyW-1:0] left_key;
    logic [ValW-1:0]        left_value;
    logic                   occ;

    if (g == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_key   = key_q;
      assign left_value = value_q;
    end else begin : g_rest
      assign left_lt    = lt[g-1];
      assign left_key   = keys[g-1];
      assign left_value = vals[g-1];
    end

    assign occ = (CntW'(g) < count_q);

    skvt_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ),
      .left_lt_i    (left_lt),
      .left_key_i   (left_key),
      .left_value_i (left_value),
      .lt_o         (lt[g]),
      .eq_o         (eq[g]),
      .key_o        (keys[g]),
      .value_o      (vals[g]),
      .hit_value_o  (hvals[g])
    );
  end

  always_comb begin
    unique case (cmd_q)
      CMD_GET, CMD_GET_INS: res_value = hit ? hit_value : value_q;
      CMD_SET, CMD_SET_ALL: res_value = '0;
      default:              res_value = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) begin
        state_d = ST_CMP;
      end
      ST_CMP:   state_d = ST_APPLY;
      ST_APPLY: if (apply_go) begin
        state_d = accept ? ST_CMP : ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (apply_go) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(s_axis_tuser);
      key_q   <= s_axis_tdata[31:0];
      value_q <= s_axis_tdata[63:32];
    end
    if (apply_go) begin
      m_data_q    <= res_value;
      m_user_q[0] <= (cmd_q != CMD_SET_ALL) && hit;
      m_user_q[1] <= need_ins && full;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire

### test/sorted_key_value_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_checker
// Watches both stream channels of the sorted key/value table. It keeps its own
// sorted copy of the table, works out the reply to each accepted request, and
// compares every accepted reply with the oldest reply still owed.
// ----------------------------------------------------------------------------
module sorted_key_value_table_checker #(
  parameter int unsigned CAPACITY = skvt_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
  input  logic [1:0]  s_axis_tuser,   // cmd [1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // result_value [31:0]
  input  logic [1:0]  m_axis_tuser,   // found [0], status [1]
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned n_replies,
  output int unsigned n_found,
  output int unsigned n_refused,
  output int unsigned peak_entries
);

  import skvt_pkg::*;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            found;
    logic            status;
  } kv_reply_t;

  logic signed [KeyW-1:0] tbl_keys [CAPACITY];
  logic [ValW-1:0]        tbl_vals [CAPACITY];
  int unsigned            tbl_count;
  kv_reply_t              owed_replies [$];

  function automatic bit insert_entry(input int unsigned pos,
                                      input logic signed [KeyW-1:0] k,
                                      input logic [ValW-1:0] v);
    int unsigned i;
    if (tbl_count >= CAPACITY) return 1'b0;
    for (i = tbl_count; i > pos; i--) begin
      tbl_keys[i] = tbl_keys[i-1];
      tbl_vals[i] = tbl_vals[i-1];
    end
    tbl_keys[pos] = k;
    tbl_vals[pos] = v;
    tbl_count++;
    if (tbl_count > peak_entries) peak_entries = tbl_count;
    return 1'b1;
  endfunction

  task automatic lookup_and_update(input cmd_e op, input logic signed [KeyW-1:0] k,
                                   input logic [ValW-1:0] v, output kv_reply_t r);
    int unsigned pos;
    int unsigned i;
    logic hit;
    r = '0;
    if (op == CMD_SET_ALL) begin
      for (i = 0; i < tbl_count; i++) tbl_vals[i] = v;
    end else begin
      pos = 0;
      while (pos < tbl_count && tbl_keys[pos] < k) pos++;
      hit = (pos < tbl_count) && (tbl_keys[pos] == k);
      r.found = hit;
      case (op)
        CMD_GET: begin
          r.value = hit ? tbl_vals[pos] : v;
        end
        CMD_SET: begin
          if (hit) tbl_vals[pos] = v;
          else if (!insert_entry(pos, k, v)) r.status = 1'b1;
        end
        default: begin
          if (hit) begin
            r.value = tbl_vals[pos];
          end else begin
            r.value = v;
            if (!insert_entry(pos, k, v)) r.status = 1'b1;
          end
        end
      endcase
    end
  endtask

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kv_reply_t want;
    kv_reply_t got;
    if (!rst_ni) begin
      tbl_count = 0;
      owed_replies.delete();
      fail_count = 0;
      pending_count = 0;
      n_replies = 0;
      n_found = 0;
      n_refused = 0;
      peak_entries = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.value  = m_axis_tdata;
        got.found  = m_axis_tuser[0];
        got.status = m_axis_tuser[1];
        n_replies++;
        if (got.found === 1'b1) n_found++;
        if (got.status === 1'b1) n_refused++;
        if (owed_replies.size() == 0) begin
          log_failure($sformatf("reply with none owed: value=%h found=%b status=%b",
                                got.value, got.found, got.status));
        end else begin
          want = owed_replies.pop_front();
          if (got !== want) begin
            log_failure($sformatf({"reply mismatch: exp value=%h found=%b status=%b,",
                                   " got value=%h found=%b status=%b"},
                                  want.value, want.found, want.status,
                                  got.value, got.found, got.status));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lookup_and_update(cmd_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32],
                          want);
        owed_replies.push_back(want);
      end
      pending_count = owed_replies.size();
    end
  end

endmodule

### test/sorted_key_value_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_tb
// Drives get, set, get-or-insert and set-all requests into the sorted
// key/value table: a directed opening on the extreme keys, then random
// requests that fill the table to capacity and keep hitting it when full.
// Both stream sides idle at random; a checker module scores every reply.
// ----------------------------------------------------------------------------
module sorted_key_value_table_tb;

  import skvt_pkg::*;

  localparam int unsigned Capacity    = DefCapacity;
  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // key [31:0], value [63:32]
  logic [1:0]  s_axis_tuser;   // cmd [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // result_value [31:0]
  logic [1:0]  m_axis_tuser;   // found [0], status [1]

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned n_replies;
  int unsigned n_found;
  int unsigned n_refused;
  int unsigned peak_entries;

  int unsigned n_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;
  logic [31:0] key_pool [$];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  sorted_key_value_table #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  sorted_key_value_table_checker #(
    .CAPACITY(Capacity)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .n_replies    (n_replies),
    .n_found      (n_found),
    .n_refused    (n_refused),
    .peak_entries (peak_entries)
  );

  // result side stall pattern
  int unsigned ready_mode;
  int unsigned ready_left;
  int unsigned ready_tick;

  initial begin
    ready_mode = 0;
    ready_left = 0;
    ready_tick = 0;
  end

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = (ready_mode == 3) ? $urandom_range(1, 16) : $urandom_range(8, 64);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (ready_tick % 3 == 0);
      default: m_axis_tready <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no request or reply moved for %0d cycles", IdleLimit);
        $display("sorted_key_value_table_tb failed");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_request(input cmd_e op, input logic [31:0] k, input logic [31:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      s_axis_tuser  <= 2'($urandom_range(0, 3));
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    n_sent++;
    if (op == CMD_SET || op == CMD_GET_INS) key_pool.push_back(k);
  endtask

  initial begin
    int unsigned i;
    int unsigned pick;
    cmd_e        op;
    logic [31:0] k;
    logic [31:0] v;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    n_sent        = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table, extreme keys, front/back/middle inserts, updates, set-all
    issue_request(CMD_GET,     32'h0000_0000, 32'hFFFF_FFFF);
    issue_request(CMD_SET_ALL, 32'h1234_5678, 32'hA5A5_A5A5);
    issue_request(CMD_GET_INS, 32'h0000_0000, 32'h1234_5678);
    issue_request(CMD_SET,     32'h8000_0000, 32'hFFFF_FFFF);
    issue_request(CMD_SET,     32'h7FFF_FFFF, 32'h0000_0000);
    issue_request(CMD_SET,     32'hFFFF_FFFF, 32'h5555_5555);
    issue_request(CMD_SET,     32'h0000_0001, 32'hAAAA_AAAA);
    issue_request(CMD_GET,     32'h8000_0000, 32'h0000_0000);
    issue_request(CMD_GET,     32'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue_request(CMD_GET,     32'hFFFF_FFFE, 32'hDEAD_BEEF);
    issue_request(CMD_GET_INS, 32'h0000_0000, 32'h0000_0000);
    issue_request(CMD_SET,     32'h0000_0000, 32'hFFFF_FFFF);
    issue_request(CMD_SET_ALL, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
    issue_request(CMD_GET,     32'hFFFF_FFFF, 32'h0000_0000);
    issue_request(CMD_SET_ALL, 32'h0000_0000, 32'h0000_0000);
    issue_request(CMD_GET,     32'h0000_0001, 32'hFFFF_FFFF);
    issue_request(CMD_GET_INS, 32'h7FFF_FFFE, 32'hF0F0_F0F0);
    issue_request(CMD_GET,     32'h8000_0001, 32'h8000_0001);
    issue_request(CMD_GET_INS, 32'h8000_0001, 32'h7FFF_FFFF);
    issue_request(CMD_GET,     32'h8000_0001, 32'h0000_0000);

    // random part: the table fills up, then full-table refusals dominate
    for (i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = CMD_GET;
      else if (pick < 62) op = CMD_SET;
      else if (pick < 95) op = CMD_GET_INS;
      else                op = CMD_SET_ALL;
      pick = $urandom_range(0, 99);
      if (pick < 45 && key_pool.size() > 0) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else if (pick < 55 && key_pool.size() > 0) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        k = $urandom_range(0, 1) ? k + 32'd1 : k - 32'd1;
      end else if (pick < 65) begin
        case ($urandom_range(0, 4))
          0:       k = 32'h8000_0000;
          1:       k = 32'h7FFF_FFFF;
          2:       k = 32'h0000_0000;
          3:       k = 32'hFFFF_FFFF;
          default: k = 32'h0000_0001;
        endcase
      end else begin
        k = $urandom;
      end
      case ($urandom_range(0, 9))
        0:       v = 32'h0000_0000;
        1:       v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      issue_request(op, k, v);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d requests, checked %0d replies: %0d hits, %0d refused inserts",
             n_sent, n_replies, n_found, n_refused);
    $display("table grew to %0d of %0d entries; %0d mismatches", peak_entries, Capacity,
             fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("sorted_key_value_table_tb passed");
    end else begin
      $display("sorted_key_value_table_tb failed");
    end
    $finish;
  end

endmodule
